// ----- hw/rtl/fbpa_pkg.sv -----
// fbpa_pkg: shared constants, widths and codes of the fixed block pool allocator
`default_nettype none

package fbpa_pkg;

  // pool geometry
  localparam int unsigned PoolDepth = 1024;
  localparam int unsigned IdxW      = $clog2(PoolDepth);
  localparam int unsigned LinkW     = IdxW + 1;  // one more bit, so the end-of-list marker fits

  // field widths
  localparam int unsigned CmdW      = 2;
  localparam int unsigned OffInW    = 32;
  localparam int unsigned StatusW   = 3;
  localparam int unsigned OutOffW   = 26;
  localparam int unsigned SizeW     = 16;
  localparam int unsigned CountW    = 11;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 16;

  // divider
  localparam int unsigned DvdW      = OffInW - 1;
  localparam int unsigned StepW     = $clog2(DvdW);

  // configuration reset values
  localparam logic [SizeW-1:0]  SizeReset  = SizeW'(4);
  localparam logic [CountW-1:0] CountReset = CountW'(1024);
  localparam logic [SizeW-1:0]  MinSize    = SizeW'(4);

  // end-of-list marker
  localparam logic [LinkW-1:0] EmptyMark = LinkW'(PoolDepth);

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgBlockSize  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgBlockCount = CfgIdxW'(1);

  // commands
  localparam logic [CmdW-1:0] CmdRebuild = CmdW'(0);
  localparam logic [CmdW-1:0] CmdAlloc   = CmdW'(1);
  localparam logic [CmdW-1:0] CmdFree    = CmdW'(2);
  localparam logic [CmdW-1:0] CmdNone    = CmdW'(3);

  // result status codes
  localparam logic [StatusW-1:0] StAllocated = StatusW'(0);
  localparam logic [StatusW-1:0] StEmpty     = StatusW'(1);
  localparam logic [StatusW-1:0] StFreed     = StatusW'(2);
  localparam logic [StatusW-1:0] StRejected  = StatusW'(3);
  localparam logic [StatusW-1:0] StRebuilt   = StatusW'(4);

endpackage

`default_nettype wire

// ----- hw/rtl/fixed_block_pool_allocator.sv -----
// fixed_block_pool_allocator: free list pool allocator around a single link memory
// rebuild sweeps the link memory (answered from idle when count is 0), allocate reads
// the head link then writes back (answered from idle when the pool is empty), free runs the
// 31-step bit-serial divider (answered from idle when rejected for a null or negative pointer); one command at a time
// each result shows on done_o for one cycle and cannot be stalled by the receiver
// reset clears the list head to empty and the config to size 4, count 1024;
// the link memory is not cleared and is only read after a rebuild or free wrote it
`default_nettype none

module fixed_block_pool_allocator
  import fbpa_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  output      logic                busy_o,
  input  wire logic [CmdW-1:0]     cmd_i,
  input  wire logic                no_pointer_i,
  input  wire logic signed [OffInW-1:0] free_offset_i,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  output      logic                done_o,
  output      logic [StatusW-1:0]  status_o,
  output      logic [IdxW-1:0]     block_index_o,
  output      logic [OutOffW-1:0]  block_offset_o
);

  typedef enum logic [2:0] {
    StIdle,
    StInit,
    StAllocRd,
    StAllocWb,
    StDivide,
    StFreeWb
  } state_e;

  state_e state_q;

  logic [SizeW-1:0]  size_q;
  logic [CountW-1:0] count_q;
  logic [LinkW-1:0]  head_q;
  logic [LinkW-1:0]  init_cnt_q;
  logic [DvdW-1:0]   dvd_q;
  logic [SizeW-1:0]  rem_q;
  logic [StepW-1:0]  step_q;

  logic               done_q;
  logic [StatusW-1:0] status_q;
  logic [IdxW-1:0]    index_q;
  logic [OutOffW-1:0] offset_q;

  // link memory
  logic [LinkW-1:0] link_mem [PoolDepth];
  logic [LinkW-1:0] rd_q;
  logic             mem_we;
  logic [IdxW-1:0]  mem_waddr;
  logic [LinkW-1:0] mem_wdata;
  logic             mem_re;

  // effective configuration
  logic [SizeW-1:0] eff_size;
  logic [LinkW-1:0] eff_count;

  assign eff_size  = (size_q < MinSize) ? MinSize : size_q;
  assign eff_count = (32'(count_q) > 32'(PoolDepth)) ? LinkW'(PoolDepth) : LinkW'(count_q);

  // rebuild sweep
  logic [LinkW-1:0] init_nxt;
  logic [LinkW-1:0] init_link;
  assign init_nxt  = init_cnt_q + LinkW'(1);
  assign init_link = (init_nxt < eff_count) ? init_nxt : EmptyMark;

  // one restoring divide step per cycle
  logic [SizeW:0]   rem_sh;
  logic [SizeW:0]   rem_sub;
  logic             q_bit;
  logic [SizeW-1:0] rem_d;
  assign rem_sh  = {rem_q, dvd_q[DvdW-1]};
  assign rem_sub = rem_sh - {1'b0, eff_size};
  assign q_bit   = ~rem_sub[SizeW];
  assign rem_d   = q_bit ? rem_sub[SizeW-1:0] : rem_sh[SizeW-1:0];

  logic free_ok;
  assign free_ok = (rem_q == '0) && (dvd_q < DvdW'(eff_count));

  // allocated offset
  logic [IdxW+SizeW-1:0] alloc_prod;
  assign alloc_prod = {{SizeW{1'b0}}, head_q[IdxW-1:0]} * {{IdxW{1'b0}}, eff_size};

  logic accept;
  assign accept = start_i && (state_q == StIdle);

  assign mem_we    = (state_q == StInit) || ((state_q == StFreeWb) && free_ok);
  assign mem_waddr = (state_q == StInit) ? init_cnt_q[IdxW-1:0] : dvd_q[IdxW-1:0];
  assign mem_wdata = (state_q == StInit) ? init_link : head_q;
  assign mem_re    = (state_q == StAllocRd);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= link_mem[head_q[IdxW-1:0]];
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q  <= SizeReset;
      count_q <= CountReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgBlockSize:  size_q  <= cfg_wdata_i[SizeW-1:0];
        CfgBlockCount: count_q <= cfg_wdata_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // control and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      head_q     <= EmptyMark;
      init_cnt_q <= '0;
      step_q     <= '0;
      done_q     <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (accept) begin
            case (cmd_i)
              CmdRebuild: begin
                init_cnt_q <= '0;
                if (eff_count == '0) begin
                  head_q   <= EmptyMark;
                  done_q   <= 1'b1;
                  status_q <= StRebuilt;
                  index_q  <= '0;
                  offset_q <= '0;
                end else begin
                  state_q <= StInit;
                end
              end
              CmdAlloc: begin
                if (head_q >= EmptyMark) begin
                  done_q   <= 1'b1;
                  status_q <= StEmpty;
                  index_q  <= '0;
                  offset_q <= '0;
                end else begin
                  state_q <= StAllocRd;
                end
              end
              CmdFree: begin
                if (no_pointer_i || free_offset_i[OffInW-1]) begin
                  done_q   <= 1'b1;
                  status_q <= StRejected;
                  index_q  <= '0;
                  offset_q <= '0;
                end else begin
                  dvd_q   <= free_offset_i[DvdW-1:0];
                  rem_q   <= '0;
                  step_q  <= '0;
                  state_q <= StDivide;
                end
              end
              default: ;
            endcase
          end
        end
        StInit: begin
          init_cnt_q <= init_nxt;
          if (init_nxt >= eff_count) begin
            head_q   <= '0;
            done_q   <= 1'b1;
            status_q <= StRebuilt;
            index_q  <= '0;
            offset_q <= '0;
            state_q  <= StIdle;
          end
        end
        StAllocRd: begin
          state_q <= StAllocWb;
        end
        StAllocWb: begin
          head_q   <= rd_q;
          done_q   <= 1'b1;
          status_q <= StAllocated;
          index_q  <= head_q[IdxW-1:0];
          offset_q <= OutOffW'(alloc_prod);
          state_q  <= StIdle;
        end
        StDivide: begin
          dvd_q  <= {dvd_q[DvdW-2:0], q_bit};
          rem_q  <= rem_d;
          step_q <= step_q + StepW'(1);
          if (step_q == StepW'(DvdW - 1)) begin
            state_q <= StFreeWb;
          end
        end
        StFreeWb: begin
          done_q   <= 1'b1;
          offset_q <= '0;
          if (free_ok) begin
            head_q   <= dvd_q[LinkW-1:0];
            status_q <= StFreed;
            index_q  <= dvd_q[IdxW-1:0];
          end else begin
            status_q <= StRejected;
            index_q  <= '0;
          end
          state_q <= StIdle;
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign busy_o         = (state_q != StIdle);
  assign done_o         = done_q;
  assign status_o       = status_q;
  assign block_index_o  = index_q;
  assign block_offset_o = offset_q;

endmodule

`default_nettype wire

// ----- hw/rtl/fbpa_checker.sv -----
// fbpa_checker: port-level checks of the pool allocator and its bind
`default_nettype none

module fbpa_checker
  import fbpa_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                start_i,
  input wire logic                busy_o,
  input wire logic [CmdW-1:0]     cmd_i,
  input wire logic                done_o,
  input wire logic [StatusW-1:0]  status_o,
  input wire logic [IdxW-1:0]     block_index_o,
  input wire logic [OutOffW-1:0]  block_offset_o
);

  // a result carries a defined status
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o == StAllocated || status_o == StEmpty || status_o == StFreed ||
                status_o == StRejected || status_o == StRebuilt))
    else $error("undefined result status");

  // only an allocation reports an offset
  a_offset_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != StAllocated) |-> (block_offset_o == '0))
    else $error("offset on a non-allocate result");

  // only allocate and free report an index
  a_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != StAllocated && status_o != StFreed) |-> (block_index_o == '0))
    else $error("index on a result without an element");

  // an unused command leaves the block idle and produces no transfer
  a_unused_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && cmd_i == CmdNone) |=> (!busy_o && !done_o))
    else $error("unused command had an effect");

  // a result only appears once the block has gone idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result while still busy");

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .cmd_i          (cmd_i),
  .done_o         (done_o),
  .status_o       (status_o),
  .block_index_o  (block_index_o),
  .block_offset_o (block_offset_o)
);

`default_nettype wire
